// ===== src/cau_pkg.sv =====
// Package for the complex arithmetic unit: beat types, operation and status codes,
// datapath widths, the arctangent table and the saturation helpers.
// Depends on nothing; every module of the block imports it.
package cau_pkg;

   localparam int DW      = 16;            // operand and result width
   localparam int FB      = 8;             // fraction bits
   localparam int FUNC_W  = 3;
   localparam int PW      = 2 * DW;        // product width
   localparam int DQW     = DW + 1;        // quotient bits produced by the divider
   localparam int DIV_PRE = DQW - FB - 1;  // right shift of the dividend that forms the first remainder
   localparam int PKW     = PW - FB + 1;   // magnitude width handed to the saturator
   localparam int CW      = DW + 4;        // CORDIC x and y width
   localparam int ZW      = 34;            // CORDIC angle width, radians scaled by 2^30
   localparam int ITERS   = 28;            // CORDIC iterations, one iteration stage each
   localparam int ANG_SH  = 30 - FB;
   localparam int QDEPTH  = 2;
   localparam int LIM_POS = 2 ** (DW - 1) - 1;
   localparam int LIM_NEG = 2 ** (DW - 1);

   localparam logic signed [DW:0]   WIDE_MAX = (DW + 1)'(LIM_POS);
   localparam logic signed [DW:0]   WIDE_MIN = (DW + 1)'(-LIM_NEG);
   localparam logic signed [ZW-1:0] PI_Q30   = ZW'(64'sd3373259426);

   localparam logic signed [ZW-1:0] ATAN_TAB [ITERS] = '{
      ZW'(843314856), ZW'(497837829), ZW'(263043836), ZW'(133525158), ZW'(67021686),
      ZW'(33543515), ZW'(16775850), ZW'(8388437), ZW'(4194282), ZW'(2097149),
      ZW'(1048575), ZW'(524287), ZW'(262143), ZW'(131071), ZW'(65535), ZW'(32767),
      ZW'(16383), ZW'(8191), ZW'(4095), ZW'(2047), ZW'(1023), ZW'(511), ZW'(255),
      ZW'(127), ZW'(63), ZW'(31), ZW'(15), ZW'(8)
   };

   typedef enum logic [FUNC_W-1:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_CONJ = 3'd4,
      OP_MAG  = 3'd5,
      OP_ARG  = 3'd6,
      OP_NONE = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_SAT      = 2'd2
   } st_type;

   typedef struct packed {
      logic [FUNC_W-1:0]     func;
      logic signed [DW-1:0]  a_re;
      logic signed [DW-1:0]  a_im;
      logic signed [DW-1:0]  b_re;
      logic signed [DW-1:0]  b_im;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0]  res_re;
      logic signed [DW-1:0]  res_im;
      logic [1:0]            status;
   } rsp_type;

   typedef struct packed {
      op_type                op;
      logic signed [DW-1:0]  a_re;
      logic signed [DW-1:0]  a_im;
      logic signed [DW-1:0]  b_re;
      logic signed [DW-1:0]  b_im;
   } work_type;

   typedef struct packed {
      logic                  sat;
      logic signed [DW-1:0]  val;
   } val_type;

   typedef struct packed {
      logic signed [CW-1:0]  x;
      logic signed [CW-1:0]  y;
      logic signed [ZW-1:0]  z;
      logic                  zero;
   } cor_type;

   typedef struct packed {
      op_type                op;
      val_type               s_re;
      val_type               s_im;
      logic                  neg_re;
      logic                  neg_im;
      logic [PW-1:0]         mag_re;
      logic [PW-1:0]         mag_im;
      logic [PW-1:0]         den;
      logic                  dz;
      logic                  dov_re;
      logic                  dov_im;
      logic [PW-1:0]         dr_re;
      logic [PW-1:0]         dr_im;
      logic [DQW-1:0]        dq_re;
      logic [DQW-1:0]        dq_im;
      logic [PW-1:0]         sq_rem;
      logic [DW-1:0]         sq_root;
      cor_type               cor;
   } it_type;

   // Clamp a sign and magnitude pair into the signed result range.
   function automatic val_type sat_pack(input logic neg, input logic [PKW-1:0] mag);
      val_type r;
      r.sat = 1'b0;
      if (!neg) begin
         if (mag > PKW'(LIM_POS)) begin
            r.sat = 1'b1;
            r.val = DW'(LIM_POS);
         end else begin
            r.val = mag[DW-1:0];
         end
      end else begin
         if (mag > PKW'(LIM_NEG)) begin
            r.sat = 1'b1;
            r.val = DW'(-LIM_NEG);
         end else begin
            r.val = DW'(PKW'(0) - mag);
         end
      end
      return r;
   endfunction

   // Clamp a value one bit wider than the result.
   function automatic val_type sat_wide(input logic signed [DW:0] s);
      val_type r;
      r.sat = 1'b0;
      if (s > WIDE_MAX) begin
         r.sat = 1'b1;
         r.val = DW'(LIM_POS);
      end else if (s < WIDE_MIN) begin
         r.sat = 1'b1;
         r.val = DW'(-LIM_NEG);
      end else begin
         r.val = s[DW-1:0];
      end
      return r;
   endfunction

endpackage

// ===== src/cau_front.sv =====
// Front end of the complex arithmetic unit: takes request beats, decodes the
// operation and holds them in a two-entry queue for the execution pipeline.
// Depends on cau_pkg.
module cau_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  cau_pkg::req_type  req_data,
   output logic              head_valid,
   output cau_pkg::work_type head,
   input  logic              head_take
);
   import cau_pkg::*;

   work_type       mem_ff [QDEPTH];
   work_type       entry;
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           push;

   assign req_full   = (count_ff == 2'(QDEPTH));
   assign head_valid = (count_ff != 2'd0);
   assign head       = mem_ff[rd_ptr_ff];
   assign push       = req_push && !req_full;

   always_comb begin
      entry.a_re = req_data.a_re;
      entry.a_im = req_data.a_im;
      entry.b_re = req_data.b_re;
      entry.b_im = req_data.b_im;
      unique case (op_type'(req_data.func))
         OP_ADD:  entry.op = OP_ADD;
         OP_SUB:  entry.op = OP_SUB;
         OP_MUL:  entry.op = OP_MUL;
         OP_DIV:  entry.op = OP_DIV;
         OP_CONJ: entry.op = OP_CONJ;
         OP_MAG:  entry.op = OP_MAG;
         OP_ARG:  entry.op = OP_ARG;
         default: entry.op = OP_NONE;
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(head_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ===== src/cau_exec.sv =====
// Execution pipeline of the complex arithmetic unit: products, sums, operand setup, then
// one stage per CORDIC step; the early stages also carry a divider and a square root step.
// Depends on cau_pkg.
module cau_exec (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  cau_pkg::work_type head,
   output logic              head_take,
   input  logic              out_full,
   output logic              out_push,
   output cau_pkg::rsp_type  out_data
);
   import cau_pkg::*;

   logic                  adv;

   // Product stage.
   logic                  v_p_ff;
   op_type                p_op_ff;
   logic signed [PW-1:0]  prod_ff [6];
   logic signed [PW-1:0]  prod_in [6];
   val_type               p_sre_ff, p_sim_ff, p_sre_in, p_sim_in;
   cor_type               p_cor_ff, p_cor_in;
   logic signed [DW-1:0]  sq_a, sq_b;

   // Sum stage.
   logic                  v_q_ff;
   op_type                q_op_ff;
   logic signed [PW:0]    q_re_ff, q_im_ff, q_re_in, q_im_in;
   logic [PW-1:0]         q_den_ff, q_den_in;
   val_type               q_sre_ff, q_sim_ff;
   cor_type               q_cor_ff;

   // Iteration stages; entry 0 holds the prepared operands.
   logic                  v_it_ff [ITERS+1];
   it_type                it_ff [ITERS+1];
   it_type                it_in [ITERS+1];

   assign adv       = !out_full;
   assign head_take = adv && head_valid;

   // ---- product stage ----
   assign sq_a = (head.op == OP_DIV) ? head.b_re : head.a_re;
   assign sq_b = (head.op == OP_DIV) ? head.b_im : head.a_im;

   always_comb begin
      prod_in[0] = PW'(head.a_re) * PW'(head.b_re);
      prod_in[1] = PW'(head.a_im) * PW'(head.b_im);
      prod_in[2] = PW'(head.a_re) * PW'(head.b_im);
      prod_in[3] = PW'(head.a_im) * PW'(head.b_re);
      prod_in[4] = PW'(sq_a) * PW'(sq_a);
      prod_in[5] = PW'(sq_b) * PW'(sq_b);
   end

   always_comb begin
      p_sre_in = '0;
      p_sim_in = '0;
      unique case (head.op)
         OP_ADD: begin
            p_sre_in = sat_wide((DW + 1)'(head.a_re) + (DW + 1)'(head.b_re));
            p_sim_in = sat_wide((DW + 1)'(head.a_im) + (DW + 1)'(head.b_im));
         end
         OP_SUB: begin
            p_sre_in = sat_wide((DW + 1)'(head.a_re) - (DW + 1)'(head.b_re));
            p_sim_in = sat_wide((DW + 1)'(head.a_im) - (DW + 1)'(head.b_im));
         end
         OP_CONJ: begin
            p_sre_in = sat_wide((DW + 1)'(head.a_re));
            p_sim_in = sat_wide(-(DW + 1)'(head.a_im));
         end
         default: begin
            p_sre_in = '0;
            p_sim_in = '0;
         end
      endcase
   end

   // Fold the left half plane over before vectoring.
   always_comb begin
      p_cor_in.x    = CW'(head.a_re);
      p_cor_in.y    = CW'(head.a_im);
      p_cor_in.z    = '0;
      p_cor_in.zero = (head.a_re == '0) && (head.a_im == '0);
      if (head.a_re < 0) begin
         p_cor_in.z = (head.a_im >= 0) ? PI_Q30 : -PI_Q30;
         p_cor_in.x = -CW'(head.a_re);
         p_cor_in.y = -CW'(head.a_im);
      end
   end

   // ---- sum stage ----
   always_comb begin
      q_den_in = PW'($unsigned(prod_ff[4]) + $unsigned(prod_ff[5]));
      unique case (p_op_ff)
         OP_MUL: begin
            q_re_in = (PW + 1)'(prod_ff[0]) - (PW + 1)'(prod_ff[1]);
            q_im_in = (PW + 1)'(prod_ff[2]) + (PW + 1)'(prod_ff[3]);
         end
         OP_DIV: begin
            q_re_in = (PW + 1)'(prod_ff[0]) + (PW + 1)'(prod_ff[1]);
            q_im_in = (PW + 1)'(prod_ff[3]) - (PW + 1)'(prod_ff[2]);
         end
         default: begin
            q_re_in = '0;
            q_im_in = '0;
         end
      endcase
   end

   // ---- operand preparation into iteration entry 0 ----
   always_comb begin
      it_in[0]         = '0;
      it_in[0].op      = q_op_ff;
      it_in[0].s_re    = q_sre_ff;
      it_in[0].s_im    = q_sim_ff;
      it_in[0].neg_re  = q_re_ff[PW];
      it_in[0].neg_im  = q_im_ff[PW];
      it_in[0].mag_re  = q_re_ff[PW] ? PW'(-q_re_ff) : PW'(q_re_ff);
      it_in[0].mag_im  = q_im_ff[PW] ? PW'(-q_im_ff) : PW'(q_im_ff);
      it_in[0].den     = q_den_ff;
      it_in[0].dz      = (q_den_ff == '0);
      it_in[0].dr_re   = it_in[0].mag_re >> DIV_PRE;
      it_in[0].dr_im   = it_in[0].mag_im >> DIV_PRE;
      // A quotient that needs more than DQW bits always saturates.
      it_in[0].dov_re  = (it_in[0].dr_re >= q_den_ff);
      it_in[0].dov_im  = (it_in[0].dr_im >= q_den_ff);
      it_in[0].sq_rem  = q_den_ff;
      it_in[0].sq_root = '0;
      it_in[0].cor     = q_cor_ff;
   end

   // ---- iteration stages ----
   for (genvar k = 0; k < ITERS; k++) begin : g_iter
      it_type                cur, nx;
      logic [PW-1:0]         dr_re_n, dr_im_n, rem_n;
      logic [DQW-1:0]        dq_re_n, dq_im_n;
      logic [DW-1:0]         root_n;
      logic signed [CW-1:0]  xs, ys;

      assign cur = it_ff[k];

      if (k < DQW) begin : g_div
         localparam int QI = DQW - 1 - k;
         logic        db_re, db_im;
         logic [PW:0] r2_re, r2_im, dd;
         if (QI >= FB + 1) begin : g_bit
            assign db_re = cur.mag_re[QI-FB-1];
            assign db_im = cur.mag_im[QI-FB-1];
         end else begin : g_zero
            assign db_re = 1'b0;
            assign db_im = 1'b0;
         end
         assign dd    = {1'b0, cur.den};
         assign r2_re = {cur.dr_re, db_re};
         assign r2_im = {cur.dr_im, db_im};
         always_comb begin
            dq_re_n = cur.dq_re;
            dq_im_n = cur.dq_im;
            if (r2_re >= dd) begin
               dr_re_n     = PW'(r2_re - dd);
               dq_re_n[QI] = 1'b1;
            end else begin
               dr_re_n = r2_re[PW-1:0];
            end
            if (r2_im >= dd) begin
               dr_im_n     = PW'(r2_im - dd);
               dq_im_n[QI] = 1'b1;
            end else begin
               dr_im_n = r2_im[PW-1:0];
            end
         end
      end else begin : g_ndiv
         assign dr_re_n = cur.dr_re;
         assign dr_im_n = cur.dr_im;
         assign dq_re_n = cur.dq_re;
         assign dq_im_n = cur.dq_im;
      end

      if (k < DW) begin : g_sqrt
         localparam int RI = DW - 1 - k;
         logic [PW+1:0] trial;
         assign trial = ((PW + 2)'(cur.sq_root) << (RI + 1)) + ((PW + 2)'(1) << (2 * RI));
         always_comb begin
            rem_n  = cur.sq_rem;
            root_n = cur.sq_root;
            if ((PW + 2)'(cur.sq_rem) >= trial) begin
               rem_n      = PW'((PW + 2)'(cur.sq_rem) - trial);
               root_n[RI] = 1'b1;
            end
         end
      end else begin : g_nsqrt
         assign rem_n  = cur.sq_rem;
         assign root_n = cur.sq_root;
      end

      assign xs = cur.cor.x >>> k;
      assign ys = cur.cor.y >>> k;

      always_comb begin
         nx         = cur;
         nx.dr_re   = dr_re_n;
         nx.dr_im   = dr_im_n;
         nx.dq_re   = dq_re_n;
         nx.dq_im   = dq_im_n;
         nx.sq_rem  = rem_n;
         nx.sq_root = root_n;
         if (!cur.cor.y[CW-1]) begin
            nx.cor.x = cur.cor.x + ys;
            nx.cor.y = cur.cor.y - xs;
            nx.cor.z = cur.cor.z + ATAN_TAB[k];
         end else begin
            nx.cor.x = cur.cor.x - ys;
            nx.cor.y = cur.cor.y + xs;
            nx.cor.z = cur.cor.z - ATAN_TAB[k];
         end
      end

      assign it_in[k+1] = nx;
   end

   // ---- result selection from the last stage ----
   it_type               fin;
   val_type              f_re, f_im;
   logic                 f_dz;
   logic [ZW-1:0]        zmag;
   logic [ZW-1:0]        zrnd;

   assign fin  = it_ff[ITERS];
   assign zmag = fin.cor.z[ZW-1] ? ZW'(-fin.cor.z) : ZW'(fin.cor.z);
   assign zrnd = (zmag + (ZW'(1) << (ANG_SH - 1))) >> ANG_SH;

   always_comb begin
      f_re = '0;
      f_im = '0;
      f_dz = 1'b0;
      unique case (fin.op)
         OP_ADD, OP_SUB, OP_CONJ: begin
            f_re = fin.s_re;
            f_im = fin.s_im;
         end
         OP_MUL: begin
            f_re = sat_pack(fin.neg_re,
                            PKW'(fin.mag_re >> FB) + PKW'(fin.mag_re[FB-1]));
            f_im = sat_pack(fin.neg_im,
                            PKW'(fin.mag_im >> FB) + PKW'(fin.mag_im[FB-1]));
         end
         OP_DIV: begin
            if (fin.dz) begin
               f_dz = 1'b1;
            end else begin
               f_re = fin.dov_re ? sat_pack(fin.neg_re, '1)
                                 : sat_pack(fin.neg_re, (PKW'(fin.dq_re) + PKW'(1)) >> 1);
               f_im = fin.dov_im ? sat_pack(fin.neg_im, '1)
                                 : sat_pack(fin.neg_im, (PKW'(fin.dq_im) + PKW'(1)) >> 1);
            end
         end
         OP_MAG: begin
            f_re = sat_pack(1'b0, PKW'(fin.sq_root)
                                  + PKW'(fin.sq_rem > PW'(fin.sq_root)));
         end
         OP_ARG: begin
            if (!fin.cor.zero) begin
               f_re = sat_pack(fin.cor.z[ZW-1], PKW'(zrnd));
            end
         end
         default: begin
            f_re = '0;
            f_im = '0;
         end
      endcase
   end

   always_comb begin
      out_data.res_re = f_re.val;
      out_data.res_im = f_im.val;
      if (f_dz) begin
         out_data.status = ST_DIV_ZERO;
      end else if (f_re.sat || f_im.sat) begin
         out_data.status = ST_SAT;
      end else begin
         out_data.status = ST_OK;
      end
   end

   assign out_push = adv && v_it_ff[ITERS];

   // ---- registers; the whole pipeline holds while the result queue is full ----
   always_ff @(posedge clock) begin
      if (reset) begin
         v_p_ff <= 1'b0;
         v_q_ff <= 1'b0;
         for (int i = 0; i <= ITERS; i++) begin
            v_it_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         v_p_ff     <= head_valid;
         v_q_ff     <= v_p_ff;
         v_it_ff[0] <= v_q_ff;
         for (int i = 0; i < ITERS; i++) begin
            v_it_ff[i+1] <= v_it_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_op_ff  <= head.op;
         p_sre_ff <= p_sre_in;
         p_sim_ff <= p_sim_in;
         p_cor_ff <= p_cor_in;
         for (int i = 0; i < 6; i++) begin
            prod_ff[i] <= prod_in[i];
         end
         q_op_ff  <= p_op_ff;
         q_re_ff  <= q_re_in;
         q_im_ff  <= q_im_in;
         q_den_ff <= q_den_in;
         q_sre_ff <= p_sre_ff;
         q_sim_ff <= p_sim_ff;
         q_cor_ff <= p_cor_ff;
         for (int i = 0; i <= ITERS; i++) begin
            it_ff[i] <= it_in[i];
         end
      end
   end

endmodule

// ===== src/cau_outq.sv =====
// Result queue of the complex arithmetic unit: two entries that decouple the
// execution pipeline from the consumer. Depends on cau_pkg.
module cau_outq (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_push,
   input  cau_pkg::rsp_type in_data,
   output logic             in_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output cau_pkg::rsp_type rsp_data
);
   import cau_pkg::*;

   rsp_type     mem_ff [QDEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   assign in_full   = (count_ff == 2'(QDEPTH));
   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign push      = in_push && !in_full;
   assign pop       = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== src/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit: request queue, execution pipeline
// and result queue. Depends on cau_pkg, cau_front, cau_exec and cau_outq.
//
//   Channel   Ports                          Beat taken when
//   request   req_push, req_full, req_data   req_push && !req_full
//   response  rsp_pop, rsp_empty, rsp_data   rsp_pop && !rsp_empty
//
// One beat per cycle is accepted while req_full is low, and one result per cycle is delivered while rsp_empty is low.
// A request passes through the request queue, the product, sum and operand setup
// stages, the 28 CORDIC stages (which also carry the 17 divider and 16 square root
// steps) and the result queue before its result shows on rsp_data.
// Synchronous active-high reset empties both queues and the pipeline.
// While the result queue holds two unread beats the pipeline freezes;
// the request queue then fills and raises req_full.
module complex_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  cau_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output cau_pkg::rsp_type rsp_data
);
   import cau_pkg::*;

   logic      head_valid;
   logic      head_take;
   work_type  head;
   logic      out_full;
   logic      out_push;
   rsp_type   out_data;

   cau_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .head_valid (head_valid),
      .head       (head),
      .head_take  (head_take)
   );

   cau_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_take  (head_take),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_data   (out_data)
   );

   cau_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .in_push    (out_push),
      .in_data    (out_data),
      .in_full    (out_full),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
